### rtl/kdmc_pkg.sv
// shared types and constants for the keypad debounce and mode control block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kdmc_pkg;

    localparam int KEY_W  = 6;
    localparam int MODE_W = 3;
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0]  STABLE_RESET = 8'd30;
    localparam logic [CNT_W-1:0]  CNT_MAX      = 8'hFF;
    localparam logic [KEY_W-1:0]  KEYS_RELEASED = 6'h3F;

    localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'h1;
    localparam logic [MODE_W-1:0] MODE_BALANCE = 3'h2;
    localparam logic [MODE_W-1:0] MODE_DRIVING = 3'h4;

    // key combinations, bit i is key i+1
    localparam logic [KEY_W-1:0] COMBO_34 = 6'b001100;
    localparam logic [KEY_W-1:0] COMBO_25 = 6'b010010;

    typedef struct packed {
        logic [KEY_W-1:0]  events;
        logic [KEY_W-1:0]  record;
        logic [MODE_W-1:0] mode;
        logic              confirmed;
    } t_result;

endpackage

`default_nettype wire

### rtl/kdmc_core.sv
// debounce state, press record and mode register with their update logic
// depends on kdmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module kdmc_core
    import kdmc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [KEY_W-1:0] i_levels,
    input  wire logic [CNT_W-1:0] i_stable_samples,
    output t_result               o_result
);

    logic [KEY_W-1:0]  r_snap,  n_snap;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic              r_done,  n_done;
    logic [KEY_W-1:0]  r_rec,   n_rec;
    logic [MODE_W-1:0] r_mode,  n_mode;

    logic [CNT_W-1:0]  thr;
    logic [CNT_W-1:0]  cnt_inc;
    logic [KEY_W-1:0]  rel;
    logic [KEY_W-1:0]  events;
    logic [MODE_W-1:0] m34;
    logic [MODE_W-1:0] m25;
    logic              conf;

    assign thr     = (i_stable_samples == '0) ? CNT_W'(1) : i_stable_samples;
    assign cnt_inc = (r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;
    assign rel     = r_snap & r_rec;

    // event order: inc, dec, line up, line down, page up, page down
    assign events = {rel[3], rel[2], rel[4], rel[1], rel[5], rel[0]};

    always_comb begin
        m34 = r_mode;
        if ((rel & COMBO_34) == COMBO_34) begin
            if ((r_mode & MODE_DISPLAY) != '0) begin
                m34 = (r_mode & ~MODE_DISPLAY) | MODE_BALANCE;
            end else if ((r_mode & MODE_BALANCE) != '0) begin
                m34 = (r_mode & ~MODE_BALANCE) | MODE_DISPLAY;
            end else begin
                m34 = (r_mode & ~(MODE_BALANCE | MODE_DRIVING)) | MODE_DISPLAY;
            end
        end
        m25 = m34;
        if ((rel & COMBO_25) == COMBO_25) begin
            if ((m34 & MODE_DRIVING) != '0) begin
                m25 = (m34 & ~MODE_DRIVING) | MODE_DISPLAY;
            end else begin
                m25 = (m34 & ~(MODE_DISPLAY | MODE_BALANCE)) | MODE_DRIVING;
            end
        end
    end

    always_comb begin
        n_snap = r_snap;
        n_cnt  = r_cnt;
        n_done = r_done;
        n_rec  = r_rec;
        n_mode = r_mode;
        conf   = 1'b0;
        if (i_levels != r_snap) begin
            n_snap = i_levels;
            n_cnt  = '0;
            n_done = 1'b0;
        end else if (!r_done) begin
            n_cnt = cnt_inc;
            if (cnt_inc >= thr) begin
                conf   = 1'b1;
                n_done = 1'b1;
                n_mode = m25;
                n_rec  = ~r_snap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= KEYS_RELEASED;
            r_cnt  <= '0;
            r_done <= 1'b1;
            r_rec  <= '0;
            r_mode <= '0;
        end else if (i_step) begin
            r_snap <= n_snap;
            r_cnt  <= n_cnt;
            r_done <= n_done;
            r_rec  <= n_rec;
            r_mode <= n_mode;
        end
    end

    always_comb begin
        o_result.events    = conf ? events : '0;
        o_result.record    = n_rec;
        o_result.mode      = n_mode;
        o_result.confirmed = conf;
    end

endmodule

`default_nettype wire

### rtl/keypad_debounce_mode_control_top.sv
// top level: input register, debounce core, result register, config register
// depends on kdmc_pkg and kdmc_core
// datapath: an accepted beat is held in the input register, then moves to the result register and is valid there
// throughput: one beat per cycle while i_out_ready is high; the core updates its state as a beat moves
// from the input register to the result register, o_in_ready follows i_out_ready when both are full
// reset: synchronous active low; threshold 30, all keys released, record and mode clear
`timescale 1ns / 1ps
`default_nettype none

module keypad_debounce_mode_control_top
    import kdmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [KEY_W-1:0]  i_key_levels,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [KEY_W-1:0]       o_action_events,
    output logic [KEY_W-1:0]       o_pressed_record,
    output logic [MODE_W-1:0]      o_mode_bits,
    output logic                   o_confirmed
);

    logic [CNT_W-1:0] r_stable_samples;
    logic             r_in_valid;
    logic [KEY_W-1:0] r_in_levels;
    logic             r_out_valid;
    t_result          r_out;
    t_result          core_result;
    logic             adv;

    // a beat leaves the input register when the result register is free or draining
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_samples <= STABLE_RESET;
        end else if (i_cfg_valid) begin
            r_stable_samples <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_levels <= i_key_levels;
        end
    end

    kdmc_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (adv),
        .i_levels         (r_in_levels),
        .i_stable_samples (r_stable_samples),
        .o_result         (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action_events  = r_out.events;
    assign o_pressed_record = r_out.record;
    assign o_mode_bits      = r_out.mode;
    assign o_confirmed      = r_out.confirmed;

endmodule

`default_nettype wire
